// ===== design/hrt_pkg.sv =====
// ----------------------------------------------------------------------------
// hrt_pkg
// shared types, phase codes and character constants for the request
// header tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package hrt_pkg;

  // parse phases
  localparam logic [3:0] PH_METHOD   = 4'd0;
  localparam logic [3:0] PH_PATH     = 4'd1;
  localparam logic [3:0] PH_QUERY    = 4'd2;
  localparam logic [3:0] PH_VERSION  = 4'd3;
  localparam logic [3:0] PH_LINE_LF  = 4'd4;
  localparam logic [3:0] PH_LINE_BEG = 4'd5;
  localparam logic [3:0] PH_HNAME    = 4'd6;
  localparam logic [3:0] PH_SKIP     = 4'd7;
  localparam logic [3:0] PH_HVAL     = 4'd8;
  localparam logic [3:0] PH_BLANK    = 4'd9;
  localparam logic [3:0] PH_DISCARD  = 4'd10;

  // token kinds
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_METHOD = 3'd1;
  localparam logic [2:0] KIND_PATH   = 3'd2;
  localparam logic [2:0] KIND_QKEY   = 3'd3;
  localparam logic [2:0] KIND_QVAL   = 3'd4;
  localparam logic [2:0] KIND_HNAME  = 3'd5;
  localparam logic [2:0] KIND_HVAL   = 3'd6;

  // status codes
  localparam logic [1:0] STATUS_BUSY = 2'd0;
  localparam logic [1:0] STATUS_DONE = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  // characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [3:0] VERSION_LEN = 4'd8;
  localparam logic [2:0] TERM_DONE   = 3'd4;

  typedef struct packed {
    logic [3:0] phase;
    logic [2:0] term_cnt;
    logic [3:0] ver_idx;
    logic       ver_bad;
    logic       path_seen;
    logic       query_eq;
  } hrt_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] token_kind;
    logic       token_end;
    logic       pair_keep;
    logic [1:0] status;
  } hrt_result_t;

  localparam hrt_state_t STATE_RESET = '{
    phase: PH_METHOD, term_cnt: 3'd0, ver_idx: 4'd0,
    ver_bad: 1'b0, path_seen: 1'b0, query_eq: 1'b0
  };

  // expected version string, one character per index
  function automatic logic [7:0] version_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h48; // H
      3'd1:    ch = 8'h54; // T
      3'd2:    ch = 8'h54; // T
      3'd3:    ch = 8'h50; // P
      3'd4:    ch = 8'h2F; // /
      3'd5:    ch = 8'h31; // 1
      3'd6:    ch = 8'h2E; // .
      default: ch = 8'h31; // 1
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== design/hrt_if.sv =====
// ----------------------------------------------------------------------------
// hrt_if
// valid/ready channels for request bytes and for token results
// ----------------------------------------------------------------------------
`default_nettype none

interface hrt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface hrt_tok_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] token_kind;
  logic       token_end;
  logic       pair_keep;
  logic [1:0] status;

  modport source (output valid, output out_byte, output token_kind,
                  output token_end, output pair_keep, output status, input ready);
  modport sink   (input valid, input out_byte, input token_kind,
                  input token_end, input pair_keep, input status, output ready);
endinterface

`default_nettype wire

// ===== design/hrt_step.sv =====
// ----------------------------------------------------------------------------
// hrt_step
// per-byte parse logic: next state and result for one request byte
// ----------------------------------------------------------------------------
`default_nettype none

module hrt_step (
  input  wire hrt_pkg::hrt_state_t  state,
  input  wire logic [7:0]           data_byte,
  output hrt_pkg::hrt_state_t       state_next,
  output hrt_pkg::hrt_result_t      result
);

  logic [2:0] tc_next;
  logic       ver_hit;

  // cr-lf-cr-lf counter: cr expected on even counts, lf on odd
  always_comb begin
    if (!state.term_cnt[0]) begin
      tc_next = (data_byte == hrt_pkg::CH_CR) ? state.term_cnt + 3'd1 : 3'd0;
    end else begin
      tc_next = (data_byte == hrt_pkg::CH_LF) ? state.term_cnt + 3'd1 : 3'd0;
    end
  end

  assign ver_hit = (state.ver_idx < hrt_pkg::VERSION_LEN) &&
                   (data_byte == hrt_pkg::version_char(state.ver_idx[2:0]));

  always_comb begin
    state_next = state;
    state_next.term_cnt = tc_next;
    result = '0;
    if (tc_next >= hrt_pkg::TERM_DONE) begin
      if (state.phase == hrt_pkg::PH_BLANK) begin
        result.status = hrt_pkg::STATUS_DONE;
      end else if (state.phase < hrt_pkg::PH_BLANK) begin
        result.status = hrt_pkg::STATUS_BAD;
      end
      state_next = hrt_pkg::STATE_RESET;
    end else begin
      unique case (state.phase)
        hrt_pkg::PH_METHOD: begin
          result.token_kind = hrt_pkg::KIND_METHOD;
          if (data_byte == hrt_pkg::CH_SP) begin
            result.token_end     = 1'b1;
            state_next.phase     = hrt_pkg::PH_PATH;
            state_next.path_seen = 1'b0;
          end else begin
            result.out_byte = data_byte;
          end
        end
        hrt_pkg::PH_PATH: begin
          if (data_byte == hrt_pkg::CH_SP) begin
            if (!state.path_seen) begin
              result.status    = hrt_pkg::STATUS_BAD;
              state_next.phase = hrt_pkg::PH_DISCARD;
            end else begin
              result.token_kind  = hrt_pkg::KIND_PATH;
              result.token_end   = 1'b1;
              state_next.phase   = hrt_pkg::PH_VERSION;
              state_next.ver_idx = 4'd0;
              state_next.ver_bad = 1'b0;
            end
          end else if (data_byte == hrt_pkg::CH_QM) begin
            state_next.path_seen = 1'b1;
            result.token_kind    = hrt_pkg::KIND_PATH;
            result.token_end     = 1'b1;
            state_next.phase     = hrt_pkg::PH_QUERY;
            state_next.query_eq  = 1'b0;
          end else begin
            state_next.path_seen = 1'b1;
            result.token_kind    = hrt_pkg::KIND_PATH;
            result.out_byte      = data_byte;
          end
        end
        hrt_pkg::PH_QUERY: begin
          if (!state.query_eq) begin
            result.token_kind = hrt_pkg::KIND_QKEY;
            if (data_byte == hrt_pkg::CH_EQ) begin
              result.token_end    = 1'b1;
              result.pair_keep    = 1'b1;
              state_next.query_eq = 1'b1;
            end else if (data_byte == hrt_pkg::CH_AMP) begin
              result.token_end = 1'b1;
            end else if (data_byte == hrt_pkg::CH_SP) begin
              result.token_end   = 1'b1;
              state_next.phase   = hrt_pkg::PH_VERSION;
              state_next.ver_idx = 4'd0;
              state_next.ver_bad = 1'b0;
            end else begin
              result.out_byte = data_byte;
            end
          end else begin
            result.token_kind = hrt_pkg::KIND_QVAL;
            if (data_byte == hrt_pkg::CH_AMP) begin
              result.token_end    = 1'b1;
              state_next.query_eq = 1'b0;
            end else if (data_byte == hrt_pkg::CH_SP) begin
              result.token_end    = 1'b1;
              state_next.query_eq = 1'b0;
              state_next.phase    = hrt_pkg::PH_VERSION;
              state_next.ver_idx  = 4'd0;
              state_next.ver_bad  = 1'b0;
            end else begin
              result.out_byte = data_byte;
            end
          end
        end
        hrt_pkg::PH_VERSION: begin
          if (data_byte == hrt_pkg::CH_CR) begin
            if (state.ver_bad || state.ver_idx != hrt_pkg::VERSION_LEN) begin
              result.status    = hrt_pkg::STATUS_BAD;
              state_next.phase = hrt_pkg::PH_DISCARD;
            end else begin
              state_next.phase = hrt_pkg::PH_LINE_LF;
            end
          end else if (ver_hit) begin
            state_next.ver_idx = state.ver_idx + 4'd1;
          end else begin
            state_next.ver_bad = 1'b1;
          end
        end
        hrt_pkg::PH_LINE_LF: begin
          state_next.phase = hrt_pkg::PH_LINE_BEG;
        end
        hrt_pkg::PH_LINE_BEG: begin
          if (data_byte == hrt_pkg::CH_CR) begin
            state_next.phase = hrt_pkg::PH_BLANK;
          end else if (data_byte == hrt_pkg::CH_COLON) begin
            result.token_kind = hrt_pkg::KIND_HNAME;
            result.token_end  = 1'b1;
            state_next.phase  = hrt_pkg::PH_SKIP;
          end else begin
            result.token_kind = hrt_pkg::KIND_HNAME;
            result.out_byte   = data_byte;
            state_next.phase  = hrt_pkg::PH_HNAME;
          end
        end
        hrt_pkg::PH_HNAME: begin
          if (data_byte == hrt_pkg::CH_COLON) begin
            result.token_kind = hrt_pkg::KIND_HNAME;
            result.token_end  = 1'b1;
            state_next.phase  = hrt_pkg::PH_SKIP;
          end else if (data_byte == hrt_pkg::CH_CR) begin
            result.status    = hrt_pkg::STATUS_BAD;
            state_next.phase = hrt_pkg::PH_DISCARD;
          end else begin
            result.token_kind = hrt_pkg::KIND_HNAME;
            result.out_byte   = data_byte;
          end
        end
        hrt_pkg::PH_SKIP: begin
          state_next.phase = hrt_pkg::PH_HVAL;
        end
        hrt_pkg::PH_HVAL: begin
          result.token_kind = hrt_pkg::KIND_HVAL;
          if (data_byte == hrt_pkg::CH_CR) begin
            result.token_end = 1'b1;
            state_next.phase = hrt_pkg::PH_LINE_LF;
          end else begin
            result.out_byte = data_byte;
          end
        end
        hrt_pkg::PH_BLANK: begin
          // cr at line start not followed by lf
          result.status    = hrt_pkg::STATUS_BAD;
          state_next.phase = hrt_pkg::PH_DISCARD;
        end
        default: begin
          state_next.phase = hrt_pkg::PH_DISCARD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/http_request_header_tokenizer.sv =====
// ----------------------------------------------------------------------------
// http_request_header_tokenizer
// streams tagged token bytes, token ends and a final status from request bytes
// ----------------------------------------------------------------------------
// usage:
//   req carries one request byte per transaction; tok carries exactly one
//   result per byte (token byte, token end marker, status, or all zero).
//   a byte is captured into an input register, then parsed by the per-byte
//   logic and written into the result register, which drives tok, once that
//   register is empty or tok takes the result it holds. throughput is one
//   byte per cycle while tok does not stall; the loop that sets it is the
//   parse state register, updated in the same cycle as the result register.
//   the input register keeps taking bytes while a result waits, as long as
//   the byte in the input register can move on; when tok stalls and both
//   registers are full, req.ready drops until tok takes the waiting result.
//   synchronous reset (rst) empties both registers and returns the parser
//   to the method phase with all counters cleared.
//   after status 1 or 2 at the header end the parser is back in the method
//   phase for the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_header_tokenizer (
  input  wire logic   clk,
  input  wire logic   rst,
  hrt_byte_if.sink    req,
  hrt_tok_if.source   tok
);

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 res_valid;
  hrt_pkg::hrt_result_t res;
  hrt_pkg::hrt_state_t  state;
  hrt_pkg::hrt_state_t  state_next;
  hrt_pkg::hrt_result_t step_res;
  logic                 advance;

  assign advance   = in_valid && (!res_valid || tok.ready);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_byte <= req.data_byte;
    end
  end

  hrt_step u_step (
    .state      (state),
    .data_byte  (in_byte),
    .state_next (state_next),
    .result     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hrt_pkg::STATE_RESET;
      res_valid <= 1'b0;
    end else begin
      if (advance) begin
        state     <= state_next;
        res_valid <= 1'b1;
      end else if (tok.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

  assign tok.valid      = res_valid;
  assign tok.out_byte   = res.out_byte;
  assign tok.token_kind = res.token_kind;
  assign tok.token_end  = res.token_end;
  assign tok.pair_keep  = res.pair_keep;
  assign tok.status     = res.status;

  // a status result never carries a token
  a_status_no_token: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != hrt_pkg::STATUS_BUSY |-> res.token_kind == hrt_pkg::KIND_NONE)
    else $error("status result carries a token kind");

  // keep flag only on a query key end
  a_keep_on_key_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.pair_keep |->
      res.token_end && res.token_kind == hrt_pkg::KIND_QKEY)
    else $error("pair_keep outside a query key end");

  // end marker carries no byte
  a_end_no_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.token_end |-> res.out_byte == 8'd0)
    else $error("token end with nonzero byte");

  // a completed header leaves the parser in the method phase with counters clear
  a_done_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && step_res.status == hrt_pkg::STATUS_DONE |=>
      state.phase == hrt_pkg::PH_METHOD && state.term_cnt == 3'd0)
    else $error("parser not restarted after header end");

endmodule

`default_nettype wire

// ===== bench/http_request_header_tokenizer_test.sv =====
// ----------------------------------------------------------------------------
// http_request_header_tokenizer_test
// drives request byte streams into the tokenizer: two short directed requests,
// then well-formed requests with random content, broken requests (faults the
// parser must reject, or a cut at a random point), and bursts of noise. every
// byte's result is predicted in the bench and compared field by field, with
// random idling on both channels except in the last stretch of the run
// ----------------------------------------------------------------------------
module http_request_header_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          MAX_REPORTS = 10;
  localparam logic [63:0] HTTP_11     = "HTTP/1.1";

  typedef enum int {
    FAULT_NONE,
    FAULT_EMPTY_PATH,
    FAULT_VERSION,
    FAULT_CR_IN_NAME,
    FAULT_BAD_BLANK,
    FAULT_CUT
  } fault_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hrt_byte_if req();
  hrt_tok_if  tok();

  http_request_header_tokenizer DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .tok(tok)
  );

  always #5 clk = ~clk;

  // parser state mirrored by the bench
  logic [3:0] phase_q;
  logic [2:0] crlf_run;
  logic [3:0] ver_pos;
  logic       ver_bad;
  logic       path_any;
  logic       key_eq;

  hrt_pkg::hrt_result_t expected_tokens[$];
  logic [7:0]           msg[$];

  int errors       = 0;
  int cycles       = 0;
  int bytes_sent   = 0;
  int parsed_bytes = 0;
  int headers_ok   = 0;
  int headers_bad  = 0;
  int stall_left   = 0;
  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;

  function automatic logic [7:0] http11_char(input int i);
    return HTTP_11[63 - 8 * i -: 8];
  endfunction

  function void parser_clear();
    phase_q  = hrt_pkg::PH_METHOD;
    crlf_run = 3'd0;
    ver_pos  = 4'd0;
    ver_bad  = 1'b0;
    path_any = 1'b0;
    key_eq   = 1'b0;
  endfunction

  function void enter_version();
    phase_q = hrt_pkg::PH_VERSION;
    ver_pos = 4'd0;
    ver_bad = 1'b0;
  endfunction

  function automatic hrt_pkg::hrt_result_t token(input logic [7:0] b,
                                                 input logic [2:0] kind,
                                                 input logic fin, input logic keep);
    hrt_pkg::hrt_result_t r;
    r.out_byte   = b;
    r.token_kind = kind;
    r.token_end  = fin;
    r.pair_keep  = keep;
    r.status     = hrt_pkg::STATUS_BUSY;
    return r;
  endfunction

  function hrt_pkg::hrt_result_t reject();
    hrt_pkg::hrt_result_t r;
    r        = '0;
    r.status = hrt_pkg::STATUS_BAD;
    phase_q  = hrt_pkg::PH_DISCARD;
    return r;
  endfunction

  // one result per byte; the terminator check comes before any phase handling
  function hrt_pkg::hrt_result_t tokenize_byte(input logic [7:0] c);
    hrt_pkg::hrt_result_t r;
    logic [3:0]           p;
    r = '0;
    p = phase_q;
    if (!crlf_run[0]) crlf_run = (c == hrt_pkg::CH_CR) ? crlf_run + 3'd1 : 3'd0;
    else crlf_run = (c == hrt_pkg::CH_LF) ? crlf_run + 3'd1 : 3'd0;
    if (crlf_run >= hrt_pkg::TERM_DONE) begin
      if (p == hrt_pkg::PH_BLANK) r.status = hrt_pkg::STATUS_DONE;
      else if (p <= hrt_pkg::PH_HVAL) r.status = hrt_pkg::STATUS_BAD;
      parser_clear();
      return r;
    end
    case (p)
      hrt_pkg::PH_METHOD: begin
        if (c == hrt_pkg::CH_SP) begin
          r        = token(8'h00, hrt_pkg::KIND_METHOD, 1'b1, 1'b0);
          phase_q  = hrt_pkg::PH_PATH;
          path_any = 1'b0;
        end else r = token(c, hrt_pkg::KIND_METHOD, 1'b0, 1'b0);
      end
      hrt_pkg::PH_PATH: begin
        if (c == hrt_pkg::CH_SP) begin
          if (!path_any) r = reject();
          else begin
            r = token(8'h00, hrt_pkg::KIND_PATH, 1'b1, 1'b0);
            enter_version();
          end
        end else if (c == hrt_pkg::CH_QM) begin
          path_any = 1'b1;
          r        = token(8'h00, hrt_pkg::KIND_PATH, 1'b1, 1'b0);
          phase_q  = hrt_pkg::PH_QUERY;
          key_eq   = 1'b0;
        end else begin
          path_any = 1'b1;
          r        = token(c, hrt_pkg::KIND_PATH, 1'b0, 1'b0);
        end
      end
      hrt_pkg::PH_QUERY: begin
        if (!key_eq) begin
          if (c == hrt_pkg::CH_EQ) begin
            r      = token(8'h00, hrt_pkg::KIND_QKEY, 1'b1, 1'b1);
            key_eq = 1'b1;
          end else if (c == hrt_pkg::CH_AMP) begin
            r = token(8'h00, hrt_pkg::KIND_QKEY, 1'b1, 1'b0);
          end else if (c == hrt_pkg::CH_SP) begin
            r = token(8'h00, hrt_pkg::KIND_QKEY, 1'b1, 1'b0);
            enter_version();
          end else r = token(c, hrt_pkg::KIND_QKEY, 1'b0, 1'b0);
        end else begin
          if (c == hrt_pkg::CH_AMP) begin
            r      = token(8'h00, hrt_pkg::KIND_QVAL, 1'b1, 1'b0);
            key_eq = 1'b0;
          end else if (c == hrt_pkg::CH_SP) begin
            r      = token(8'h00, hrt_pkg::KIND_QVAL, 1'b1, 1'b0);
            key_eq = 1'b0;
            enter_version();
          end else r = token(c, hrt_pkg::KIND_QVAL, 1'b0, 1'b0);
        end
      end
      hrt_pkg::PH_VERSION: begin
        if (c == hrt_pkg::CH_CR) begin
          if (ver_bad || ver_pos != hrt_pkg::VERSION_LEN) r = reject();
          else phase_q = hrt_pkg::PH_LINE_LF;
        end else if (ver_pos < hrt_pkg::VERSION_LEN &&
                     c == http11_char(int'(ver_pos))) begin
          ver_pos = ver_pos + 4'd1;
        end else ver_bad = 1'b1;
      end
      hrt_pkg::PH_LINE_LF: phase_q = hrt_pkg::PH_LINE_BEG;
      hrt_pkg::PH_LINE_BEG: begin
        if (c == hrt_pkg::CH_CR) phase_q = hrt_pkg::PH_BLANK;
        else if (c == hrt_pkg::CH_COLON) begin
          r       = token(8'h00, hrt_pkg::KIND_HNAME, 1'b1, 1'b0);
          phase_q = hrt_pkg::PH_SKIP;
        end else begin
          r       = token(c, hrt_pkg::KIND_HNAME, 1'b0, 1'b0);
          phase_q = hrt_pkg::PH_HNAME;
        end
      end
      hrt_pkg::PH_HNAME: begin
        if (c == hrt_pkg::CH_COLON) begin
          r       = token(8'h00, hrt_pkg::KIND_HNAME, 1'b1, 1'b0);
          phase_q = hrt_pkg::PH_SKIP;
        end else if (c == hrt_pkg::CH_CR) r = reject();
        else r = token(c, hrt_pkg::KIND_HNAME, 1'b0, 1'b0);
      end
      hrt_pkg::PH_SKIP: phase_q = hrt_pkg::PH_HVAL;
      hrt_pkg::PH_HVAL: begin
        if (c == hrt_pkg::CH_CR) begin
          r       = token(8'h00, hrt_pkg::KIND_HVAL, 1'b1, 1'b0);
          phase_q = hrt_pkg::PH_LINE_LF;
        end else r = token(c, hrt_pkg::KIND_HVAL, 1'b0, 1'b0);
      end
      hrt_pkg::PH_BLANK: r = reject();
      default: phase_q = hrt_pkg::PH_DISCARD;
    endcase
    return r;
  endfunction

  function void note_error(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("cycle %0d: %s", cycles, what);
  endfunction

  function void check_token();
    hrt_pkg::hrt_result_t want;
    hrt_pkg::hrt_result_t got;
    got.out_byte   = tok.out_byte;
    got.token_kind = tok.token_kind;
    got.token_end  = tok.token_end;
    got.pair_keep  = tok.pair_keep;
    got.status     = tok.status;
    if (got.status == hrt_pkg::STATUS_DONE) headers_ok++;
    else if (got.status == hrt_pkg::STATUS_BAD) headers_bad++;
    if (expected_tokens.size() == 0) begin
      note_error($sformatf("result with nothing outstanding: byte %02h kind %0d status %0d",
                           got.out_byte, got.token_kind, got.status));
      return;
    end
    want = expected_tokens.pop_front();
    if (got.out_byte !== want.out_byte || got.token_kind !== want.token_kind ||
        got.token_end !== want.token_end || got.pair_keep !== want.pair_keep ||
        got.status !== want.status)
      note_error($sformatf({"mismatch: expected byte %02h kind %0d end %0b keep %0b ",
                            "status %0d, got byte %02h kind %0d end %0b keep %0b status %0d"},
                           want.out_byte, want.token_kind, want.token_end, want.pair_keep,
                           want.status, got.out_byte, got.token_kind, got.token_end,
                           got.pair_keep, got.status));
  endfunction

  // result checking and stalls on the token side
  always @(posedge clk) begin
    if (!rst && tok.valid && tok.ready) check_token();
    if (stall_left > 0) begin
      stall_left--;
      tok.ready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 15);
      tok.ready <= 1'b0;
    end else begin
      tok.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("http_request_header_tokenizer_test: errors");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (src_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.data_byte <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    // bytes thrown away after an early reject do not count as parsed
    if (phase_q != hrt_pkg::PH_DISCARD) parsed_bytes++;
    expected_tokens.push_back(tokenize_byte(b));
    bytes_sent++;
  endtask

  task automatic send_msg();
    foreach (msg[i]) send_byte(msg[i]);
  endtask

  task automatic wait_drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  // random byte, mostly printable, never CR, LF or space
  function automatic logic [7:0] text_byte(input logic [7:0] x1, input logic [7:0] x2);
    logic [7:0] v;
    do begin
      if ($urandom_range(0, 3) != 0) v = 8'($urandom_range(8'h21, 8'h7E));
      else v = 8'($urandom_range(0, 255));
    end while (v == hrt_pkg::CH_CR || v == hrt_pkg::CH_LF || v == hrt_pkg::CH_SP ||
               v == x1 || v == x2);
    return v;
  endfunction

  task automatic push_text(input string s);
    foreach (s[i]) msg.push_back(s[i]);
  endtask

  task automatic push_crlf();
    msg.push_back(hrt_pkg::CH_CR);
    msg.push_back(hrt_pkg::CH_LF);
  endtask

  task automatic push_bad_version();
    int         pick;
    int         pos;
    logic [7:0] v;
    pick = $urandom_range(0, 2);
    if (pick == 0) begin
      pos = $urandom_range(0, 7);
      for (int i = 0; i < 8; i++) begin
        v = http11_char(i);
        if (i == pos) begin
          do v = text_byte(hrt_pkg::CH_CR, hrt_pkg::CH_CR); while (v == http11_char(i));
        end
        msg.push_back(v);
      end
    end else if (pick == 1) begin
      pos = $urandom_range(0, 7);
      for (int i = 0; i < pos; i++) msg.push_back(http11_char(i));
    end else begin
      push_text("HTTP/1.1");
      repeat ($urandom_range(1, 2)) msg.push_back(text_byte(hrt_pkg::CH_CR, hrt_pkg::CH_CR));
    end
  endtask

  task automatic build_request(input fault_t fault);
    int n;
    int pieces;
    int headers;
    int cut;
    msg.delete();
    repeat ($urandom_range(0, 6)) msg.push_back(text_byte(hrt_pkg::CH_SP, hrt_pkg::CH_SP));
    msg.push_back(hrt_pkg::CH_SP);
    if (fault != FAULT_EMPTY_PATH) begin
      n = $urandom_range(0, 6);
      repeat (n) msg.push_back(text_byte(hrt_pkg::CH_QM, hrt_pkg::CH_SP));
      if (n == 0 || $urandom_range(0, 1) == 1) begin
        msg.push_back(hrt_pkg::CH_QM);
        pieces = $urandom_range(0, 3);
        for (int i = 0; i < pieces; i++) begin
          if (i > 0) msg.push_back(hrt_pkg::CH_AMP);
          repeat ($urandom_range(0, 3))
            msg.push_back(text_byte(hrt_pkg::CH_EQ, hrt_pkg::CH_AMP));
          if ($urandom_range(0, 2) != 0) begin
            msg.push_back(hrt_pkg::CH_EQ);
            repeat ($urandom_range(0, 3))
              msg.push_back(text_byte(hrt_pkg::CH_AMP, hrt_pkg::CH_SP));
          end
        end
      end
    end
    msg.push_back(hrt_pkg::CH_SP);
    if (fault == FAULT_VERSION) push_bad_version();
    else push_text("HTTP/1.1");
    headers = $urandom_range(0, 3);
    if (fault == FAULT_CR_IN_NAME && headers == 0) headers = 1;
    msg.push_back(hrt_pkg::CH_CR);
    // the byte after a line-ending CR is skipped, whatever it is
    if (headers > 0 && $urandom_range(0, 7) == 0)
      msg.push_back(text_byte(hrt_pkg::CH_SP, hrt_pkg::CH_SP));
    else msg.push_back(hrt_pkg::CH_LF);
    for (int i = 0; i < headers; i++) begin
      n = $urandom_range(0, 5);
      if (fault == FAULT_CR_IN_NAME && i == headers - 1) begin
        repeat (n + 1) msg.push_back(text_byte(hrt_pkg::CH_COLON, hrt_pkg::CH_SP));
        push_crlf();
      end else begin
        repeat (n) msg.push_back(text_byte(hrt_pkg::CH_COLON, hrt_pkg::CH_SP));
        msg.push_back(hrt_pkg::CH_COLON);
        msg.push_back(($urandom_range(0, 3) == 0) ?
                      text_byte(hrt_pkg::CH_SP, hrt_pkg::CH_SP) : hrt_pkg::CH_SP);
        repeat ($urandom_range(0, 6))
          msg.push_back(text_byte(hrt_pkg::CH_CR, hrt_pkg::CH_CR));
        push_crlf();
      end
    end
    if (fault == FAULT_BAD_BLANK) begin
      msg.push_back(hrt_pkg::CH_CR);
      msg.push_back(text_byte(hrt_pkg::CH_SP, hrt_pkg::CH_SP));
      push_crlf();
      push_crlf();
    end else push_crlf();
    if (fault == FAULT_CUT) begin
      // end of header lands in whatever phase the cut leaves
      cut = $urandom_range(0, msg.size() - 1);
      while (msg.size() > cut) void'(msg.pop_back());
      push_crlf();
      push_crlf();
    end
  endtask

  task automatic test_directed();
    msg.delete();
    // null method byte, path of just '?', empty key with '=', top-value byte,
    // key without '=', empty header name and value
    msg.push_back(8'h00);
    push_text(" ?=");
    msg.push_back(8'hFF);
    push_text("&k HTTP/1.1");
    push_crlf();
    push_text(": ");
    push_crlf();
    push_crlf();
    // space straight after the method: empty path, then discard to the end
    push_text("G  ");
    push_crlf();
    push_crlf();
    send_msg();
    wait_drain();
  endtask

  task automatic test_requests(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      src_idle_on = ($urandom_range(0, 3) != 0);
      sink_idle_on <= ($urandom_range(0, 3) != 0);
      build_request(FAULT_NONE);
      send_msg();
    end
  endtask

  task automatic test_broken_requests(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      src_idle_on = ($urandom_range(0, 3) != 0);
      sink_idle_on <= ($urandom_range(0, 3) != 0);
      build_request(fault_t'($urandom_range(FAULT_EMPTY_PATH, FAULT_CUT)));
      send_msg();
    end
  endtask

  task automatic test_noise(input int budget);
    int start;
    int pick;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      msg.delete();
      repeat ($urandom_range(1, 12)) begin
        pick = $urandom_range(0, 7);
        if (pick < 2) msg.push_back(hrt_pkg::CH_CR);
        else if (pick < 4) msg.push_back(hrt_pkg::CH_LF);
        else msg.push_back(8'($urandom_range(0, 255)));
      end
      push_crlf();
      push_crlf();
      send_msg();
    end
  endtask

  task automatic test_no_idle(input int budget);
    int start;
    start = bytes_sent;
    src_idle_on = 1'b0;
    sink_idle_on <= 1'b0;
    while (bytes_sent - start < budget) begin
      if ($urandom_range(0, 4) == 0)
        build_request(fault_t'($urandom_range(FAULT_EMPTY_PATH, FAULT_CUT)));
      else build_request(FAULT_NONE);
      send_msg();
    end
  endtask

  initial begin
    req.valid     = 1'b0;
    req.data_byte = 8'h00;
    tok.ready     = 1'b0;
    parser_clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_requests(640);
    wait_drain();
    test_broken_requests(380);
    test_noise(140);
    test_no_idle(300);
    wait_drain();
    repeat (8) @(posedge clk);
    $display("sent %0d request bytes, %0d of them parsed outside discard",
             bytes_sent, parsed_bytes);
    $display("headers seen complete: %0d, rejected: %0d", headers_ok, headers_bad);
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("http_request_header_tokenizer_test: clean");
    end else begin
      $display("http_request_header_tokenizer_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/hrt_pkg.sv
design/hrt_if.sv
design/hrt_step.sv
design/http_request_header_tokenizer.sv
bench/http_request_header_tokenizer_test.sv
